/* rtl/ecsm_pkg.sv */
// ecsm_pkg: types, constants and the power table function for the ellipse / circle mask.
// Used by every module of the block; no dependencies.
package ecsm_pkg;

	localparam int PIX_W  = 12;
	localparam int MASK_W = 8;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 3;
	localparam int NITER  = 16;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_FRAME_LEFT   = 3'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_TOP    = 3'd1;
	localparam logic [IDX_W-1:0] REG_FRAME_RIGHT  = 3'd2;
	localparam logic [IDX_W-1:0] REG_FRAME_BOTTOM = 3'd3;
	localparam logic [IDX_W-1:0] REG_CENTER_X     = 3'd4;
	localparam logic [IDX_W-1:0] REG_CENTER_Y     = 3'd5;
	localparam logic [IDX_W-1:0] REG_WIDTH_PX     = 3'd6;
	localparam logic [IDX_W-1:0] REG_HEIGHT_PX    = 3'd7;

	typedef struct packed {
		logic signed [15:0] frame_left;
		logic signed [15:0] frame_top;
		logic signed [15:0] frame_right;
		logic signed [15:0] frame_bottom;
		logic signed [15:0] center_x;
		logic signed [15:0] center_y;
		logic [14:0]        width_px;
		logic [14:0]        height_px;
	} cfg_t;

	// state carried through the iteration stages
	typedef struct packed {
		logic        circ;
		logic [7:0]  mask;
		logic        c_out;
		logic        c_full;
		logic        c_kz;
		logic [47:0] c_k;
		logic [47:0] c_s;
		logic [38:0] c_p;
		logic [29:0] c_r2;
		logic [7:0]  c_m;
		logic        e_out;
		logic [59:0] e_dn;
		logic [59:0] e_rem;
		logic [16:0] e_c;
	} iter_t;

	// entry i = round(65536 * (i * 2^-bits)^0.35)
	function automatic logic [16:0] pow_entry(input int i, input int bits);
		real r;
		r = 65536.0 * $pow(real'(i) * $pow(2.0, -real'(bits)), 0.35);
		return 17'($rtoi(r + 0.5));
	endfunction

endpackage

/* rtl/ecsm_front.sv */
// ecsm_front: geometry, box tests, products and the start values of both searches.
// Five pipeline stages; uses ecsm_pkg.
module ecsm_front (
	input  logic                   clk,
	input  logic [4:0]             en,
	input  logic [11:0]            x,
	input  logic [11:0]            y,
	input  logic [7:0]             mask,
	input  ecsm_pkg::cfg_t         cfg,
	output ecsm_pkg::iter_t        st
);

	// stage 1
	logic signed [16:0] dfx, dfy, rad17;
	logic signed [15:0] rad;
	logic signed [17:0] cx, cy, ex, ey, ax18, ay18;
	logic signed [18:0] rr, bb, xs, ys, dxw, dyw;
	logic inbox, e_bad;

	logic               circ_s1, cout_s1, cfull_s1, eout_s1;
	logic [7:0]         mask_s1;
	logic signed [15:0] dx_s1, dy_s1, rad_s1;
	logic [13:0]        ax_s1, ay_s1;
	logic [14:0]        w_s1, h_s1;

	always_comb begin
		dfx   = {cfg.frame_right[15], cfg.frame_right} - {cfg.frame_left[15], cfg.frame_left};
		dfy   = {cfg.frame_bottom[15], cfg.frame_bottom} - {cfg.frame_top[15], cfg.frame_top};
		rad17 = (dfx + {16'b0, dfx[16]}) >>> 1;
		rad   = rad17[15:0];
		cx    = {{2{cfg.frame_left[15]}}, cfg.frame_left} + {{2{rad[15]}}, rad};
		cy    = {{2{cfg.frame_top[15]}}, cfg.frame_top} + {{2{rad[15]}}, rad};
		rr    = {cx[17], cx} + {{3{rad[15]}}, rad};
		bb    = {cy[17], cy} + {{3{rad[15]}}, rad};
		xs    = {7'b0, x};
		ys    = {7'b0, y};
		inbox = (xs >= $signed({{3{cfg.frame_left[15]}}, cfg.frame_left}))
			&& (ys >= $signed({{3{cfg.frame_top[15]}}, cfg.frame_top}))
			&& (xs <= rr) && (ys <= bb);
		dxw   = xs - {cx[17], cx};
		dyw   = ys - {cy[17], cy};
		ex    = {6'b0, x} - {{2{cfg.center_x[15]}}, cfg.center_x};
		ey    = {6'b0, y} - {{2{cfg.center_y[15]}}, cfg.center_y};
		ax18  = ex[17] ? -ex : ex;
		ay18  = ey[17] ? -ey : ey;
		e_bad = (cfg.width_px == 15'd0) || (cfg.height_px == 15'd0)
			|| ({ax18[16:0], 1'b0} > {3'b0, cfg.width_px})
			|| ({ay18[16:0], 1'b0} > {3'b0, cfg.height_px});
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			circ_s1  <= (dfx == dfy);
			mask_s1  <= mask;
			cout_s1  <= !inbox;
			cfull_s1 <= inbox && (rad[15] || (rad == 16'sd0));
			dx_s1    <= dxw[15:0];
			dy_s1    <= dyw[15:0];
			rad_s1   <= rad;
			eout_s1  <= e_bad;
			ax_s1    <= ax18[13:0];
			ay_s1    <= ay18[13:0];
			w_s1     <= cfg.width_px;
			h_s1     <= cfg.height_px;
		end
	end

	// stage 2: first products
	logic signed [31:0] dxx, dyy, rsq;
	logic               circ_s2, cout_s2, cfull_s2, eout_s2;
	logic [7:0]         mask_s2;
	logic [29:0]        dxx_s2, dyy_s2, r2_s2, wh_s2;
	logic [28:0]        hx_s2, wy_s2;

	always_comb begin
		dxx = dx_s1 * dx_s1;
		dyy = dy_s1 * dy_s1;
		rsq = rad_s1 * rad_s1;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			circ_s2  <= circ_s1;
			mask_s2  <= mask_s1;
			cout_s2  <= cout_s1;
			cfull_s2 <= cfull_s1;
			eout_s2  <= eout_s1;
			dxx_s2   <= dxx[29:0];
			dyy_s2   <= dyy[29:0];
			r2_s2    <= rsq[29:0];
			hx_s2    <= h_s1 * ax_s1;
			wy_s2    <= w_s1 * ay_s1;
			wh_s2    <= w_s1 * h_s1;
		end
	end

	// stage 3: distance sum and squares
	logic [30:0] dsum;
	logic        circ_s3, cout_s3, cfull_s3, eout_s3;
	logic [7:0]  mask_s3;
	logic [30:0] d_s3;
	logic [29:0] r2_s3;
	logic [59:0] dn_s3;
	logic [57:0] t1_s3, t2_s3;

	assign dsum = {1'b0, dxx_s2} + {1'b0, dyy_s2};

	always_ff @(posedge clk) begin
		if (en[2]) begin
			circ_s3  <= circ_s2;
			mask_s3  <= mask_s2;
			cout_s3  <= cout_s2 || (dsum > {1'b0, r2_s2});
			cfull_s3 <= cfull_s2;
			eout_s3  <= eout_s2;
			d_s3     <= dsum;
			r2_s3    <= r2_s2;
			dn_s3    <= wh_s2 * wh_s2;
			t1_s3    <= hx_s2 * hx_s2;
			t2_s3    <= wy_s2 * wy_s2;
		end
	end

	// stage 4: scaled distance and ellipse term sum
	logic        circ_s4, cout_s4, cfull_s4, eout_s4;
	logic [7:0]  mask_s4;
	logic [47:0] k_s4;
	logic [29:0] r2_s4;
	logic [59:0] dn_s4;
	logic [58:0] ts_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			circ_s4  <= circ_s3;
			mask_s4  <= mask_s3;
			cout_s4  <= cout_s3;
			cfull_s4 <= cfull_s3;
			eout_s4  <= eout_s3;
			k_s4     <= {17'b0, d_s3} * 48'd65025;
			r2_s4    <= r2_s3;
			dn_s4    <= dn_s3;
			ts_s4    <= {1'b0, t1_s3} + {1'b0, t2_s3};
		end
	end

	// stage 5: numerator of the curve ratio
	logic [60:0] tq;
	logic [61:0] ndiff;
	logic        tzero;

	always_comb begin
		tq    = {ts_s4, 2'b0};
		ndiff = {2'b0, dn_s4} - {1'b0, tq};
		tzero = (ts_s4 == 59'd0);
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			st.circ   <= circ_s4;
			st.mask   <= mask_s4;
			st.c_out  <= cout_s4;
			st.c_full <= cfull_s4;
			st.c_kz   <= (k_s4 == 48'd0);
			st.c_k    <= k_s4;
			st.c_s    <= 48'd0;
			st.c_p    <= 39'd0;
			st.c_r2   <= r2_s4;
			st.c_m    <= 8'd0;
			st.e_out  <= eout_s4 || ndiff[61];
			st.e_dn   <= dn_s4;
			st.e_rem  <= tzero ? 60'd0 : ndiff[59:0];
			st.e_c    <= tzero ? 17'd1 : 17'd0;
		end
	end

endmodule

/* rtl/ecsm_iter.sv */
// ecsm_iter: one pipeline step of the curve division and, in the first eight steps,
// one bit of the circle shade search. Uses ecsm_pkg.
module ecsm_iter #(
	parameter int STEP = 0
) (
	input  logic            clk,
	input  logic            en,
	input  ecsm_pkg::iter_t d,
	output ecsm_pkg::iter_t q
);

	ecsm_pkg::iter_t nx;
	logic [60:0] r2x;
	logic        ge;

	always_comb begin
		nx    = d;
		r2x   = {d.e_rem, 1'b0};
		ge    = r2x >= {1'b0, d.e_dn};
		nx.e_rem = ge ? 60'(r2x - {1'b0, d.e_dn}) : r2x[59:0];
		nx.e_c   = {d.e_c[15:0], ge};
	end

	generate
		if (STEP < 8) begin : g_circ
			localparam int B = 7 - STEP;
			ecsm_pkg::iter_t cx;
			logic [47:0] trial;
			always_comb begin
				cx    = nx;
				// (m + 2^B)^2 r^2 = S + 2^(B+1) m r^2 + 2^(2B) r^2
				trial = d.c_s + ({9'b0, d.c_p} << (B + 1)) + ({18'b0, d.c_r2} << (2 * B));
				if (trial < d.c_k) begin
					cx.c_s = trial;
					cx.c_p = 39'(d.c_p + ({9'b0, d.c_r2} << B));
					cx.c_m = d.c_m | 8'(1 << B);
				end
			end
			always_ff @(posedge clk) begin
				if (en) q <= cx;
			end
		end else begin : g_div
			always_ff @(posedge clk) begin
				if (en) q <= nx;
			end
		end
	endgenerate

endmodule

/* rtl/ecsm_back.sv */
// ecsm_back: power table lookup, shade scaling and the final minimum with the mask.
// Two pipeline stages; uses ecsm_pkg.
module ecsm_back #(
	parameter int POW_TABLE_BITS = 10
) (
	input  logic            clk,
	input  logic [1:0]      en,
	input  ecsm_pkg::iter_t d,
	output logic [7:0]      mask_out
);

	localparam int POW_SIZE = (1 << POW_TABLE_BITS) + 1;

	logic [16:0] pow_rom [POW_SIZE];

	generate
		for (genvar gi = 0; gi < POW_SIZE; gi++) begin : g_rom
			assign pow_rom[gi] = ecsm_pkg::pow_entry(gi, POW_TABLE_BITS);
		end
	endgenerate

	// stage a
	logic [16:0]               u;
	logic [17:0]               usum;
	logic [POW_TABLE_BITS+1:0] idxw;
	logic [POW_TABLE_BITS:0]   idx;
	logic [8:0]                mc;
	logic [7:0]                shc;

	logic        circ_s1, eout_s1;
	logic [7:0]  mask_s1, shc_s1;
	logic [16:0] c_s1, pow_s1;

	always_comb begin
		u    = 17'd65536 - d.e_c;
		usum = {1'b0, u} + 18'(1 << (15 - POW_TABLE_BITS));
		idxw = usum[17:16-POW_TABLE_BITS];
		if (idxw > (POW_TABLE_BITS+2)'(POW_SIZE - 1))
			idx = (POW_TABLE_BITS+1)'(POW_SIZE - 1);
		else
			idx = idxw[POW_TABLE_BITS:0];
		mc = d.c_kz ? 9'd0 : ({1'b0, d.c_m} + 9'd1);
		if (d.c_out)
			shc = 8'd0;
		else if (d.c_full)
			shc = 8'd255;
		else
			shc = 8'(9'd255 - mc);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			circ_s1 <= d.circ;
			eout_s1 <= d.e_out;
			mask_s1 <= d.mask;
			shc_s1  <= shc;
			c_s1    <= d.e_c;
			pow_s1  <= pow_rom[idx];
		end
	end

	// stage b
	logic [17:0] s;
	logic [25:0] prod;
	logic [8:0]  se;
	logic [7:0]  shade;

	always_comb begin
		s    = {1'b0, c_s1} + 18'd65536 - {1'b0, pow_s1};
		prod = {s, 8'b0} - {8'b0, s};
		se   = prod[25:17];
		if (circ_s1)
			shade = shc_s1;
		else if (eout_s1)
			shade = 8'd0;
		else if (se > 9'd255)
			shade = 8'd255;
		else
			shade = se[7:0];
	end

	always_ff @(posedge clk) begin
		if (en[1]) mask_out <= (mask_s1 < shade) ? mask_s1 : shade;
	end

endmodule

/* rtl/ellipse_circle_soft_mask.sv */
// ellipse_circle_soft_mask: top level, configuration registers, stage valids and flow control.
// Depends on ecsm_pkg, ecsm_front, ecsm_iter and ecsm_back.
//
//   channel | dir | fields (low bit up)
//   s_      | in  | tdata: pixel_x[11:0], pixel_y[23:12], mask_in[31:24]
//   m_      | out | tdata: mask_out[7:0]
//   cfg_    | in  | cfg_index selects the register, cfg_wdata[15:0] the value
//
// one pixel per clock while the output is not stalled; 5 front stages, 16 division steps
// (the circle search runs in the first 8 of them) and 2 back stages.
// arst_n clears the configuration registers and all stage valids.
// a stage loads whenever it or any stage after it is empty, so bubbles close up
// and a stalled output holds everything behind it without loss.
module ellipse_circle_soft_mask #(
	parameter int COORD_BITS     = 12,
	parameter int POW_TABLE_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // pixel_x, pixel_y, mask_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // mask_out
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	localparam int NSTAGE = 5 + ecsm_pkg::NITER + 2;
	localparam logic [11:0] CMASK = 12'((1 << COORD_BITS) - 1);

	ecsm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ecsm_pkg::REG_FRAME_LEFT:   cfg_q.frame_left   <= cfg_wdata;
				ecsm_pkg::REG_FRAME_TOP:    cfg_q.frame_top    <= cfg_wdata;
				ecsm_pkg::REG_FRAME_RIGHT:  cfg_q.frame_right  <= cfg_wdata;
				ecsm_pkg::REG_FRAME_BOTTOM: cfg_q.frame_bottom <= cfg_wdata;
				ecsm_pkg::REG_CENTER_X:     cfg_q.center_x     <= cfg_wdata;
				ecsm_pkg::REG_CENTER_Y:     cfg_q.center_y     <= cfg_wdata;
				ecsm_pkg::REG_WIDTH_PX:     cfg_q.width_px     <= cfg_wdata[14:0];
				ecsm_pkg::REG_HEIGHT_PX:    cfg_q.height_px    <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	// valid of each stage, index 1 is the first
	logic [NSTAGE:1] v_q;
	logic [NSTAGE:1] en;
	logic [NSTAGE:0] vin;

	always_comb begin
		en[NSTAGE] = m_tready || !v_q[NSTAGE];
		for (int k = NSTAGE - 1; k >= 1; k--) begin
			en[k] = en[k+1] || !v_q[k];
		end
	end

	assign vin = {v_q, s_tvalid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 1; k <= NSTAGE; k++) begin
				if (en[k]) v_q[k] <= vin[k-1];
			end
		end
	end

	assign s_tready = en[1];
	assign m_tvalid = v_q[NSTAGE];

	ecsm_pkg::iter_t pipe [ecsm_pkg::NITER+1];

	ecsm_front u_front (
		.clk  (clk),
		.en   (en[5:1]),
		.x    (s_tdata[11:0] & CMASK),
		.y    (s_tdata[23:12] & CMASK),
		.mask (s_tdata[31:24]),
		.cfg  (cfg_q),
		.st   (pipe[0])
	);

	generate
		for (genvar gi = 0; gi < ecsm_pkg::NITER; gi++) begin : g_iter
			ecsm_iter #(.STEP(gi)) u_iter (
				.clk (clk),
				.en  (en[6+gi]),
				.d   (pipe[gi]),
				.q   (pipe[gi+1])
			);
		end
	endgenerate

	ecsm_back #(.POW_TABLE_BITS(POW_TABLE_BITS)) u_back (
		.clk      (clk),
		.en       (en[NSTAGE:NSTAGE-1]),
		.d        (pipe[ecsm_pkg::NITER]),
		.mask_out (m_tdata)
	);

endmodule

/* tb/ecsm_checker.sv */
// ecsm_checker: watches the pixel, mask and configuration channels of the soft mask,
// predicts every mask byte and compares it with what the block returns.
// Depends on ecsm_pkg for the register indexes.
module ecsm_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	output int          pending,
	output int          failures
);

	localparam int TBITS = 10;
	localparam int TSIZE = (1 << TBITS) + 1;

	longint          left, top, right, bottom, cen_x, cen_y;
	longint unsigned wid, hgt;
	bit [16:0]       pow_tab [TSIZE];
	bit [7:0]        mask_q [$];

	// (2y-1)^20 <= i^7 * 2^(340 - 7*TBITS) means y is at most the rounded power
	function automatic bit pow_fits(int i, int y);
		bit [399:0] lhs, rhs;
		lhs = 1;
		rhs = 1;
		for (int k = 0; k < 20; k++)
			lhs = lhs * (2 * y - 1);
		for (int k = 0; k < 7; k++)
			rhs = rhs * i;
		rhs = rhs << (340 - 7 * TBITS);
		return lhs <= rhs;
	endfunction

	function automatic int pow_round(int i);
		int y;
		y = $rtoi(65536.0 * $pow(real'(i) / real'(1 << TBITS), 0.35) + 0.5);
		while (y > 0 && !pow_fits(i, y))
			y--;
		while (y < 65536 && pow_fits(i, y + 1))
			y++;
		return y;
	endfunction

	function automatic longint unsigned sqrt_up(longint unsigned s);
		longint unsigned res, bt, n;
		res = 0;
		bt = 64'd1 << 62;
		n = s;
		while (bt > n)
			bt >>= 2;
		while (bt != 0) begin
			if (n >= res + bt) begin
				n -= res + bt;
				res = (res >> 1) + bt;
			end else begin
				res >>= 1;
			end
			bt >>= 2;
		end
		if (res * res < s)
			res++;
		return res;
	endfunction

	function automatic longint unsigned circle_level(longint x, longint y);
		longint          rad, cx, cy, dx, dy;
		longint unsigned d, q, m;
		rad = (right - left) / 2;
		cx = left + rad;
		cy = top + rad;
		if (x < left || y < top || x > cx + rad || y > cy + rad)
			return 0;
		if (rad <= 0)
			return 255;
		dx = x - cx;
		dy = y - cy;
		d = dx * dx + dy * dy;
		if (d > rad * rad)
			return 0;
		q = sqrt_up(65025 * d);
		m = (q + rad - 1) / rad;
		return (m >= 255) ? 0 : 255 - m;
	endfunction

	function automatic longint unsigned ellipse_level(longint x, longint y);
		longint unsigned ax, ay, w2, h2, dn, t, n, c, rem, u, idx, s;
		if (wid == 0 || hgt == 0)
			return 0;
		ax = (x < cen_x) ? cen_x - x : x - cen_x;
		ay = (y < cen_y) ? cen_y - y : y - cen_y;
		if (2 * ax > wid || 2 * ay > hgt)
			return 0;
		w2 = wid * wid;
		h2 = hgt * hgt;
		dn = w2 * h2;
		t = 4 * h2 * ax * ax + 4 * w2 * ay * ay;
		if (t > dn)
			return 0;
		n = dn - t;
		c = (n >= dn) ? 1 : 0;
		rem = n - c * dn;
		for (int k = 0; k < 16; k++) begin
			rem <<= 1;
			c <<= 1;
			if (rem >= dn) begin
				rem -= dn;
				c |= 1;
			end
		end
		u = 65536 - c;
		idx = (u + (64'd1 << (15 - TBITS))) >> (16 - TBITS);
		if (idx > TSIZE - 1)
			idx = TSIZE - 1;
		s = ((c + 65536 - pow_tab[idx]) * 255) >> 17;
		return (s > 255) ? 255 : s;
	endfunction

	function automatic bit [7:0] masked_level(bit [31:0] pix);
		longint          x, y;
		longint unsigned m, lvl;
		x = pix[11:0];
		y = pix[23:12];
		m = pix[31:24];
		if (m == 0)
			return 0;
		if (right - left == bottom - top)
			lvl = circle_level(x, y);
		else
			lvl = ellipse_level(x, y);
		return (m < lvl) ? m[7:0] : lvl[7:0];
	endfunction

	initial begin
		for (int i = 0; i < TSIZE; i++)
			pow_tab[i] = pow_round(i);
	end

	assign pending = mask_q.size();

	always @(posedge clk or negedge arst_n) begin
		bit [7:0] want;
		if (!arst_n) begin
			left = 0; top = 0; right = 0; bottom = 0;
			cen_x = 0; cen_y = 0; wid = 0; hgt = 0;
			mask_q.delete();
			failures = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ecsm_pkg::REG_FRAME_LEFT:   left   = longint'($signed(cfg_wdata));
					ecsm_pkg::REG_FRAME_TOP:    top    = longint'($signed(cfg_wdata));
					ecsm_pkg::REG_FRAME_RIGHT:  right  = longint'($signed(cfg_wdata));
					ecsm_pkg::REG_FRAME_BOTTOM: bottom = longint'($signed(cfg_wdata));
					ecsm_pkg::REG_CENTER_X:     cen_x  = longint'($signed(cfg_wdata));
					ecsm_pkg::REG_CENTER_Y:     cen_y  = longint'($signed(cfg_wdata));
					ecsm_pkg::REG_WIDTH_PX:     wid    = cfg_wdata[14:0];
					ecsm_pkg::REG_HEIGHT_PX:    hgt    = cfg_wdata[14:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				mask_q.push_back(masked_level(s_tdata));
			if (m_tvalid && m_tready) begin
				if (mask_q.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("unexpected mask transfer: %0d", m_tdata);
				end else begin
					want = mask_q.pop_front();
					if (want !== m_tdata) begin
						failures++;
						if (failures <= 10)
							$display("mask_out mismatch: expected %0d, got %0d", want, m_tdata);
					end
				end
			end
		end
	end
endmodule

/* tb/tb.sv */
// tb: clock, reset and stimulus for ellipse_circle_soft_mask, with ecsm_checker beside it.
// Depends on ecsm_pkg, the block and tb/ecsm_checker.sv.
module tb;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [31:0] s_tdata = 0;   // pixel_x, pixel_y, mask_in
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [7:0]  m_tdata;       // mask_out
	logic        cfg_we = 0;
	logic [2:0]  cfg_index = ecsm_pkg::REG_FRAME_LEFT;
	logic [15:0] cfg_wdata = 0;
	int          pending, failures;
	bit          quiet_rx = 0;
	bit          quiet_tx = 0;
	longint      aim_x, aim_y, aim_span;

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	ellipse_circle_soft_mask dut (.*);

	ecsm_checker chk (.*);

	initial begin
		#(8 * 600000);
		$display("tb failed");
		$finish;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	function automatic bit [11:0] near(longint c);
		longint v;
		if ($urandom_range(0, 9) == 0)
			return 12'($urandom_range(0, 4095));
		v = c + longint'($urandom_range(0, 32'(2 * aim_span))) - aim_span;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return v[11:0];
	endfunction

	task automatic write_reg(bit [2:0] idx, bit [15:0] val);
		cfg_we = 1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
	endtask

	task automatic set_shape(int l, int t, int r, int b, int cx, int cy, int w, int h);
		write_reg(ecsm_pkg::REG_FRAME_LEFT, l[15:0]);
		write_reg(ecsm_pkg::REG_FRAME_TOP, t[15:0]);
		write_reg(ecsm_pkg::REG_FRAME_RIGHT, r[15:0]);
		write_reg(ecsm_pkg::REG_FRAME_BOTTOM, b[15:0]);
		write_reg(ecsm_pkg::REG_CENTER_X, cx[15:0]);
		write_reg(ecsm_pkg::REG_CENTER_Y, cy[15:0]);
		write_reg(ecsm_pkg::REG_WIDTH_PX, w[15:0]);
		write_reg(ecsm_pkg::REG_HEIGHT_PX, h[15:0]);
		cfg_we = 0;
		@(negedge clk);
	endtask

	// one pixel transfer; valid stays up across back-to-back items
	task automatic send_pixel(bit [11:0] x, bit [11:0] y, bit [7:0] m);
		int g;
		g = quiet_tx ? 0 : idle_len();
		if (g > 0) begin
			s_tvalid = 0;
			repeat (g) @(negedge clk);
		end
		s_tvalid = 1;
		s_tdata = {m, y, x};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid = 0;
		while (pending != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic random_pixels(int count);
		bit [7:0] m;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0:       m = 0;
				1:       m = 255;
				default: m = 8'($urandom_range(0, 255));
			endcase
			send_pixel(near(aim_x), near(aim_y), m);
		end
	endtask

	// receiver: random stalls, plus one long hold-off so the pipeline backs up
	initial begin
		int  g;
		int  cycles;
		bit  held;
		cycles = 0;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cycles++;
			if (!held && cycles > 200 && s_tvalid) begin
				held = 1;
				m_tready = 0;
				repeat (300) @(negedge clk);
			end
			g = quiet_rx ? 0 : idle_len();
			if (g > 0) begin
				m_tready = 0;
				repeat (g - 1) @(negedge clk);
			end else begin
				m_tready = 1;
			end
		end
	end

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// reset values: square zero frame, the single pixel at the origin keeps its mask
		aim_x = 0; aim_y = 0; aim_span = 3;
		send_pixel(0, 0, 255);
		send_pixel(0, 0, 0);
		send_pixel(1, 0, 200);
		send_pixel(4095, 4095, 255);
		drain();

		// circle of radius 100 at (100,100)
		set_shape(0, 0, 200, 200, 0, 0, 0, 0);
		send_pixel(100, 100, 255);
		send_pixel(100, 100, 7);
		send_pixel(100, 0, 255);
		send_pixel(200, 200, 255);
		send_pixel(201, 100, 255);
		send_pixel(170, 170, 255);
		send_pixel(150, 130, 128);
		aim_x = 100; aim_y = 100; aim_span = 110;
		quiet_tx = 1; quiet_rx = 1;
		random_pixels(60);
		quiet_tx = 0; quiet_rx = 0;
		random_pixels(60);
		drain();

		// ellipse 301 x 121 about (2000,1000)
		set_shape(0, 0, 10, 20, 2000, 1000, 301, 121);
		send_pixel(2000, 1000, 255);
		send_pixel(2150, 1000, 255);
		send_pixel(2151, 1000, 255);
		send_pixel(2000, 1060, 255);
		send_pixel(2100, 1040, 90);
		aim_x = 2000; aim_y = 1000; aim_span = 160;
		random_pixels(130);
		drain();

		// degenerate ellipses
		set_shape(0, 0, 10, 20, 50, 50, 0, 40);
		send_pixel(50, 50, 255);
		aim_x = 50; aim_y = 50; aim_span = 30;
		random_pixels(30);
		drain();
		set_shape(0, 0, 10, 20, 50, 50, 40, 0);
		random_pixels(30);
		drain();

		// negative square frame: empty box
		set_shape(10, 10, 0, 0, 0, 0, 0, 0);
		send_pixel(5, 5, 255);
		aim_x = 5; aim_y = 5; aim_span = 10;
		random_pixels(40);
		drain();

		// widest frame and widest ellipse
		set_shape(-32768, -32768, 32767, 32767, 0, 0, 0, 0);
		aim_x = 2048; aim_y = 2048; aim_span = 2048;
		random_pixels(100);
		drain();
		set_shape(-32768, 0, 32767, 1, -1, 4095, 32767, 32767);
		random_pixels(100);
		drain();
		set_shape(0, 0, 1, 2, 32767, -32768, 32767, 32767);
		random_pixels(40);
		drain();

		// small random shapes, mostly ellipses
		for (int p = 0; p < 6; p++) begin
			int l, t, s, cx, cy, w, h;
			l = $urandom_range(0, 4000) - 100;
			t = $urandom_range(0, 4000) - 100;
			s = $urandom_range(0, 300);
			cx = $urandom_range(0, 4095);
			cy = $urandom_range(0, 4095);
			w = $urandom_range(1, 600);
			h = $urandom_range(1, 600);
			if (p % 3 == 0) begin
				set_shape(l, t, l + s, t + s, cx, cy, w, h);
				aim_x = l + s / 2; aim_y = t + s / 2; aim_span = s / 2 + 5;
			end else begin
				set_shape(l, t, l + s, t + s + 1, cx, cy, w, h);
				aim_x = cx; aim_y = cy; aim_span = (w > h ? w : h) / 2 + 5;
			end
			random_pixels(55);
			drain();
		end

		if (failures == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule
